/* hw/rtl/spa_pkg.sv */
`default_nettype none

package spa_pkg;

  localparam int unsigned AddrW          = 56;
  localparam int unsigned CurW           = AddrW + 1;
  localparam int unsigned PoolEntries    = 8;
  localparam int unsigned IdxW           = (PoolEntries > 1) ? $clog2(PoolEntries) : 1;
  localparam int unsigned PageBytes      = 4096;
  localparam int unsigned LargePageBytes = 2097152;
  localparam int unsigned ReservedPages  = 64;
  localparam int unsigned CfgIdxW        = 1;

  localparam logic [CurW-1:0] PageAddend  = CurW'(PageBytes - 1);
  localparam logic [CurW-1:0] LargeAddend = CurW'(LargePageBytes - 1);
  localparam logic [CurW-1:0] LargeStep   = CurW'(LargePageBytes);
  localparam logic [CurW-1:0] ReserveStep = CurW'(ReservedPages * PageBytes);
  localparam logic [CurW-1:0] PageMask    = ~PageAddend;
  localparam logic [CurW-1:0] LargeMask   = ~LargeAddend;
  localparam logic [IdxW-1:0] LastIdx     = IdxW'(PoolEntries - 1);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_MISS      = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_KERNEL_END = 1'b0,
    CFG_PHYS_TOP   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALN_NONE  = 2'd0,
    ALN_PAGE  = 2'd1,
    ALN_LARGE = 2'd2
  } align_e;

  typedef struct packed {
    action_e          action;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] result_address;
    status_e          status;
  } rsp_t;

  typedef struct packed {
    logic [CurW-1:0]  a;
    logic [CurW-1:0]  b;
    align_e           align;
    logic [AddrW-1:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [CurW-1:0] sum;
    logic            fits;
    logic            eq;
  } alu_rsp_t;

  typedef struct packed {
    logic             we_all;
    logic             we_free;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] base;
    logic             free;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/spa_alu.sv */
`default_nettype none

module spa_alu (
  input  spa_pkg::alu_req_t req_i,
  output spa_pkg::alu_rsp_t rsp_o
);

  logic [spa_pkg::CurW-1:0] raw;

  assign raw = req_i.a + req_i.b;

  always_comb begin
    case (req_i.align)
      spa_pkg::ALN_PAGE:  rsp_o.sum = raw & spa_pkg::PageMask;
      spa_pkg::ALN_LARGE: rsp_o.sum = raw & spa_pkg::LargeMask;
      default:            rsp_o.sum = raw;
    endcase
  end

  assign rsp_o.fits = (raw <= {1'b0, req_i.limit});
  assign rsp_o.eq   = (req_i.a == req_i.b);

endmodule

`default_nettype wire

/* hw/rtl/spa_table.sv */
`default_nettype none

module spa_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spa_pkg::tbl_wr_t              wr_i,
  input  logic [spa_pkg::IdxW-1:0]      rd_idx_i,
  output logic [spa_pkg::AddrW-1:0]     rd_base_o,
  output logic                          rd_free_o
);

  logic [spa_pkg::AddrW-1:0]       base_q [spa_pkg::PoolEntries];
  logic [spa_pkg::PoolEntries-1:0] free_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_all) begin
      base_q[wr_i.idx] <= wr_i.base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
    end else if (wr_i.we_all || wr_i.we_free) begin
      free_q[wr_i.idx] <= wr_i.free;
    end
  end

  assign rd_base_o = base_q[rd_idx_i];
  assign rd_free_o = free_q[rd_idx_i];

endmodule

`default_nettype wire

/* hw/rtl/spa_seq.sv */
`default_nettype none

module spa_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  spa_pkg::req_t             req_i,
  input  logic [spa_pkg::AddrW-1:0] kernel_end_i,
  input  logic [spa_pkg::AddrW-1:0] phys_top_i,
  output logic                      busy_o,
  output logic                      rsp_valid_o,
  output spa_pkg::rsp_t             rsp_o,
  output spa_pkg::alu_req_t         alu_req_o,
  input  spa_pkg::alu_rsp_t         alu_rsp_i,
  output spa_pkg::tbl_wr_t          tbl_wr_o,
  output logic [spa_pkg::IdxW-1:0]  tbl_idx_o,
  input  logic [spa_pkg::AddrW-1:0] tbl_base_i,
  input  logic                      tbl_free_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAGE  = 7'b0000010,
    S_RSV   = 7'b0000100,
    S_ALIGN = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  spa_pkg::action_e          act_q, act_d;
  logic [spa_pkg::AddrW-1:0] addr_q, addr_d;
  logic [spa_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [spa_pkg::CurW-1:0]  cur_q, cur_d;
  logic                      open_q, open_d;
  logic                      ready_q, ready_d;
  logic [spa_pkg::AddrW-1:0] res_q, res_d;
  spa_pkg::status_e          status_q, status_d;

  logic fill_hit;
  logic scan_hit;
  logic last_idx;

  assign last_idx = (idx_q == spa_pkg::LastIdx);
  assign fill_hit = open_q && alu_rsp_i.fits;

  always_comb begin
    if (act_q == spa_pkg::ACT_ALLOC) begin
      scan_hit = tbl_free_i && !alu_rsp_i.eq;
    end else begin
      scan_hit = alu_rsp_i.eq;
    end
  end

  always_comb begin
    alu_req_o.a     = cur_q;
    alu_req_o.b     = spa_pkg::LargeStep;
    alu_req_o.align = spa_pkg::ALN_NONE;
    alu_req_o.limit = phys_top_i;
    case (state_q)
      S_PAGE: begin
        alu_req_o.a     = {1'b0, kernel_end_i};
        alu_req_o.b     = spa_pkg::PageAddend;
        alu_req_o.align = spa_pkg::ALN_PAGE;
      end
      S_RSV: begin
        alu_req_o.b = spa_pkg::ReserveStep;
      end
      S_ALIGN: begin
        alu_req_o.b     = spa_pkg::LargeAddend;
        alu_req_o.align = spa_pkg::ALN_LARGE;
      end
      S_SCAN: begin
        alu_req_o.a = {1'b0, tbl_base_i};
        alu_req_o.b = (act_q == spa_pkg::ACT_ALLOC) ? '0 : {1'b0, addr_q};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    addr_d   = addr_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    open_d   = open_q;
    ready_d  = ready_q;
    res_d    = res_q;
    status_d = status_q;

    tbl_wr_o.we_all  = 1'b0;
    tbl_wr_o.we_free = 1'b0;
    tbl_wr_o.idx     = idx_q;
    tbl_wr_o.base    = '0;
    tbl_wr_o.free    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d    = req_i.action;
          addr_d   = req_i.address;
          idx_d    = '0;
          res_d    = '0;
          status_d = spa_pkg::ST_MISS;
          if (req_i.action == spa_pkg::ACT_INIT) begin
            status_d = spa_pkg::ST_OK;
            state_d  = S_PAGE;
          end else if (!ready_q) begin
            status_d = spa_pkg::ST_NOT_READY;
            state_d  = S_DONE;
          end else if (req_i.action == spa_pkg::ACT_FREE && req_i.address == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_PAGE: begin
        cur_d   = alu_rsp_i.sum;
        state_d = S_RSV;
      end
      S_RSV: begin
        cur_d   = alu_rsp_i.sum;
        state_d = S_ALIGN;
      end
      S_ALIGN: begin
        cur_d   = alu_rsp_i.sum;
        open_d  = 1'b1;
        idx_d   = '0;
        state_d = S_FILL;
      end
      S_FILL: begin
        tbl_wr_o.we_all = 1'b1;
        tbl_wr_o.base   = fill_hit ? cur_q[spa_pkg::AddrW-1:0] : '0;
        tbl_wr_o.free   = fill_hit;
        if (fill_hit) begin
          cur_d = alu_rsp_i.sum;
        end else begin
          open_d = 1'b0;
        end
        if (last_idx) begin
          ready_d = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          status_d = spa_pkg::ST_OK;
          state_d  = S_DONE;
          if (act_q == spa_pkg::ACT_ALLOC) begin
            tbl_wr_o.we_free = 1'b1;
            tbl_wr_o.free    = 1'b0;
            res_d            = tbl_base_i;
          end else if (act_q == spa_pkg::ACT_FREE) begin
            tbl_wr_o.we_free = 1'b1;
            tbl_wr_o.free    = 1'b1;
          end
        end else if (last_idx) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      open_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      open_q  <= open_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    addr_q   <= addr_d;
    cur_q    <= cur_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign tbl_idx_o            = idx_q;
  assign busy_o               = (state_q != S_IDLE);
  assign rsp_valid_o          = (state_q == S_DONE);
  assign rsp_o.result_address = res_q;
  assign rsp_o.status         = status_q;

endmodule

`default_nettype wire

/* hw/rtl/superpage_pool_allocator.sv */
// channel   direction  signals                          transfer
// request   in         start_i, req_i                   start_i high while busy_o low
// result    out        rsp_valid_o, rsp_o               one cycle with rsp_valid_o high
// config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i every edge with cfg_we_i high
//
// init: three adder passes for the cursor then one table entry per cycle for all N
//   pool entries (N = pool entries), then the result strobe
// allocate/free/query: one table entry per cycle until a hit or the last entry;
//   not ready or free of zero skips the scan and answers directly
// reset: table empty and not ready, registers at their defaults
// the result cannot be stalled; busy_o stays high until the result cycle ends
`default_nettype none

module superpage_pool_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  spa_pkg::req_t               req_i,
  output logic                        busy_o,
  output logic                        rsp_valid_o,
  output spa_pkg::rsp_t               rsp_o,
  input  logic                        cfg_we_i,
  input  logic [spa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spa_pkg::AddrW-1:0]   cfg_wdata_i
);

  logic [spa_pkg::AddrW-1:0] kernel_end_q;
  logic [spa_pkg::AddrW-1:0] phys_top_q;

  spa_pkg::alu_req_t         alu_req;
  spa_pkg::alu_rsp_t         alu_rsp;
  spa_pkg::tbl_wr_t          tbl_wr;
  logic [spa_pkg::IdxW-1:0]  tbl_idx;
  logic [spa_pkg::AddrW-1:0] tbl_base;
  logic                      tbl_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= spa_pkg::AddrW'(64'h8000_0000);
      phys_top_q   <= spa_pkg::AddrW'(64'h8800_0000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spa_pkg::CFG_KERNEL_END: kernel_end_q <= cfg_wdata_i;
        spa_pkg::CFG_PHYS_TOP:   phys_top_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  spa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  spa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_idx_i  (tbl_idx),
    .rd_base_o (tbl_base),
    .rd_free_o (tbl_free)
  );

  spa_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .kernel_end_i (kernel_end_q),
    .phys_top_i   (phys_top_q),
    .busy_o       (busy_o),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .tbl_wr_o     (tbl_wr),
    .tbl_idx_o    (tbl_idx),
    .tbl_base_i   (tbl_base),
    .tbl_free_i   (tbl_free)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request transfer did not start work");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(rsp_valid_o))
    else $error("work ended without a result");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o && !busy_o)
    else $error("result not followed by idle");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.result_address != '0 |-> rsp_o.status == spa_pkg::ST_OK)
    else $error("address returned without success");

endmodule

`default_nettype wire
